### src/nbr_pkg.sv
// Shared types, codes and constants of the NAL bit reader.
`timescale 1ns / 1ps
`default_nettype none

package nbr_pkg;

  // Default depth of the raw byte buffer.
  localparam int unsigned BUFFER_BYTES_DEF = 4096;

  // Byte and code constants.
  localparam int unsigned BYTE_BITS = 8;
  localparam logic [7:0]  EMU_BYTE  = 8'h03;
  localparam logic [5:0]  MAX_READ_BITS = 6'd32;
  localparam logic [4:0]  UE_MAX_ZEROS  = 5'd31;

  // Command codes.
  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_REWIND = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_UE     = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EOD     = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_UE_LONG = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic [5:0] bit_count;
  } nbr_in_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [15:0] remaining_bits;
  } nbr_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_FETCH,
    ST_RESULT
  } nbr_state_t;

  typedef enum logic [1:0] {
    MODE_READ,
    MODE_UE,
    MODE_TAIL,
    MODE_REWIND
  } nbr_mode_t;

  // Operands of the shared bit extraction unit.
  typedef struct packed {
    logic [5:0]  left;
    logic [3:0]  bib;
    logic [7:0]  cur;
    logic [31:0] acc;
  } nbr_bu_in_t;

  // Results of one extraction step.
  typedef struct packed {
    logic [3:0]  take;
    logic [5:0]  left;
    logic [3:0]  bib;
    logic [7:0]  cur;
    logic [31:0] acc;
  } nbr_bu_out_t;

endpackage

`default_nettype wire

### src/nbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module nbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/nbr_bit_unit.sv
// Shared extraction unit: moves up to one byte's worth of bits into the accumulator.
`timescale 1ns / 1ps
`default_nettype none

module nbr_bit_unit
  import nbr_pkg::*;
(
  input  wire nbr_bu_in_t op,
  output nbr_bu_out_t     res
);

  logic [3:0] take;
  logic [7:0] chunk;

  // Take what is left of the current byte, or fewer if the read ends first.
  assign take  = ({2'b00, op.bib} < op.left) ? op.bib : op.left[3:0];
  assign chunk = 8'(op.cur >> (4'(BYTE_BITS) - take));

  always_comb begin
    res.take = take;
    res.left = op.left - {2'b00, take};
    res.bib  = op.bib - take;
    res.cur  = 8'(op.cur << take);
    res.acc  = (op.acc << take) | {24'h000000, chunk};
  end

endmodule

`default_nettype wire

### src/nal_bit_reader_exp_golomb_unit.sv
// Top level of the NAL bit reader with emulation prevention and ue(v) decode.
//
//  channel | ports                          | direction | beat
//  --------+--------------------------------+-----------+-------------------------------
//  in      | in_valid, in_stall, in_data    | input     | one command
//  out     | out_valid, out_stall, out_data | output    | one result per command
//  cfg     | cfg_valid, cfg_ready, cfg_data | input     | emulation_skip_enable write
//
// Path from accept back to idle: load, clear, unused commands, zero-bit
// reads and rewind of an empty buffer go straight to the result state;
// rewind of a loaded buffer first reads byte 0 in the fetch state. A bit
// read moves one byte chunk per step and fetches each new byte from the
// buffer (a second fetch when an emulation byte is dropped). ue(v) takes
// each prefix bit, then tests it, then reads the tail chunk by chunk and
// closes a nonempty tail, with the same fetches. The single buffer read
// port and the one-chunk extraction unit set these steps.
// Reset: synchronous, active low; no clearing pass, the fill count guards
// the buffer. The result register lets a new command in while the last
// beat is stalled on the output.

`timescale 1ns / 1ps
`default_nettype none

module nal_bit_reader_exp_golomb_unit
  import nbr_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  // command beats
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire nbr_in_t  in_data,
  // result beats
  output logic          out_valid,
  input  wire logic     out_stall,
  output nbr_out_t      out_data,
  // configuration
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_data
);

  localparam int unsigned AW    = $clog2(BUFFER_BYTES);
  localparam int unsigned BTW   = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned RAW_W = BTW + 3;

  // Control state.
  nbr_state_t       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [BTW-1:0]   byte_total_r, byte_total_nxt;
  logic [BTW-1:0]   fetch_r, fetch_nxt;
  logic [7:0]       cur_r, cur_nxt;
  logic [3:0]       bib_r, bib_nxt;
  logic [RAW_W-1:0] raw_r, raw_nxt;
  logic [1:0]       zrun_r, zrun_nxt;
  logic             esc_en_r;

  // Working registers of the current command.
  nbr_mode_t        mode_r, mode_nxt;
  logic [5:0]       left_r, left_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [4:0]       zeros_r, zeros_nxt;
  logic             second_r, second_nxt;
  logic             mask_r, mask_nxt;
  logic [31:0]      res_value_r, res_value_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  nbr_out_t         out_data_r, out_data_nxt;

  // Buffer port.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  nbr_bu_in_t       bu_op;
  nbr_bu_out_t      bu_res;

  logic             in_accept;
  logic             out_free;
  logic [BTW-1:0]   fetch_inc;
  logic [7:0]       fetch_byte;
  logic             read_short;
  logic             skip_hit;
  logic [5:0]       count_sat;
  logic             buf_full;
  logic [31:0]      raw_ext;
  logic [15:0]      raw_sat;
  logic [RAW_W-1:0] raw_less8;

  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign fetch_inc  = fetch_r + 1'b1;
  // Past the loaded bytes the buffer reads as zero.
  assign fetch_byte = mask_r ? ram_rdata : 8'h00;
  assign read_short = RAW_W'(left_r) > raw_r;
  assign skip_hit   = esc_en_r && (zrun_r == 2'd2) && (fetch_byte == EMU_BYTE);
  assign count_sat  = (in_data.bit_count > MAX_READ_BITS) ? MAX_READ_BITS : in_data.bit_count;
  assign buf_full   = byte_total_r >= BTW'(BUFFER_BYTES);
  assign raw_ext    = 32'(raw_r);
  assign raw_sat    = (raw_ext > 32'h0000ffff) ? 16'hffff : raw_ext[15:0];
  assign raw_less8  = (raw_r >= RAW_W'(BYTE_BITS)) ? raw_r - RAW_W'(BYTE_BITS) : '0;

  assign bu_op.left = left_r;
  assign bu_op.bib  = bib_r;
  assign bu_op.cur  = cur_r;
  assign bu_op.acc  = acc_r;

  nbr_bit_unit u_bit_unit (
    .op  (bu_op),
    .res (bu_res)
  );

  nbr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Buffer writes come only from an accepted load; reads are byte 0 on
  // rewind, else the byte after the fetch index.
  assign ram_we    = in_accept && (in_data.command == CMD_LOAD) && !buf_full;
  assign ram_waddr = byte_total_r[AW-1:0];
  assign ram_raddr = (state_r == ST_IDLE) ? '0 : fetch_inc[AW-1:0];

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_data.command)
            CMD_READ:   state_nxt = (count_sat == 6'd0) ? ST_RESULT : ST_BITS;
            CMD_UE:     state_nxt = ST_BITS;
            CMD_REWIND: state_nxt = (byte_total_r != '0) ? ST_FETCH : ST_RESULT;
            default:    state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_BITS: begin
        if (left_r == 6'd0) begin
          unique case (mode_r)
            MODE_UE: begin
              if (acc_r[0]) begin
                state_nxt = (zeros_r == 5'd0) ? ST_RESULT : ST_BITS;
              end else begin
                state_nxt = (zeros_r == UE_MAX_ZEROS) ? ST_RESULT : ST_BITS;
              end
            end
            default: state_nxt = ST_RESULT;
          endcase
        end else if (read_short) begin
          state_nxt = ST_RESULT;
        end else if (bib_r == 4'd0) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (second_r) begin
          state_nxt = (mode_r == MODE_REWIND) ? ST_RESULT : ST_BITS;
        end else if (!skip_hit) begin
          state_nxt = ST_BITS;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    byte_total_nxt = byte_total_r;
    fetch_nxt      = fetch_r;
    cur_nxt        = cur_r;
    bib_nxt        = bib_r;
    raw_nxt        = raw_r;
    zrun_nxt       = zrun_r;
    mode_nxt       = mode_r;
    left_nxt       = left_r;
    acc_nxt        = acc_r;
    zeros_nxt      = zeros_r;
    second_nxt     = second_r;
    mask_nxt       = mask_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    ram_re         = 1'b0;

    // Drop a beat the sink has taken.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          res_value_nxt  = 32'h0;
          res_status_nxt = STAT_OK;
          acc_nxt        = 32'h0;
          zeros_nxt      = 5'd0;
          case (in_data.command)
            CMD_LOAD: begin
              if (buf_full) begin
                res_status_nxt = STAT_FULL;
              end else begin
                byte_total_nxt = byte_total_r + 1'b1;
              end
            end
            CMD_REWIND: begin
              fetch_nxt = '0;
              bib_nxt   = 4'(BYTE_BITS);
              raw_nxt   = {byte_total_r, 3'b000};
              mode_nxt  = MODE_REWIND;
              if (byte_total_r != '0) begin
                ram_re     = 1'b1;
                mask_nxt   = 1'b1;
                second_nxt = 1'b1;
              end else begin
                cur_nxt  = 8'h00;
                zrun_nxt = 2'd0;
              end
            end
            CMD_READ: begin
              mode_nxt = MODE_READ;
              left_nxt = count_sat;
            end
            CMD_UE: begin
              mode_nxt = MODE_UE;
              left_nxt = 6'd1;
            end
            CMD_CLEAR: begin
              byte_total_nxt = '0;
              fetch_nxt      = '0;
              bib_nxt        = 4'(BYTE_BITS);
              raw_nxt        = '0;
              cur_nxt        = 8'h00;
              zrun_nxt       = 2'd0;
            end
            default: ;
          endcase
        end
      end
      ST_BITS: begin
        if (left_r == 6'd0) begin
          unique case (mode_r)
            MODE_READ: res_value_nxt = acc_r;
            MODE_UE: begin
              if (acc_r[0]) begin
                // Prefix ends: read the tail, or a zero-length code is 0.
                mode_nxt = MODE_TAIL;
                left_nxt = {1'b0, zeros_r};
                acc_nxt  = 32'h0;
              end else if (zeros_r == UE_MAX_ZEROS) begin
                res_status_nxt = STAT_UE_LONG;
              end else begin
                zeros_nxt = zeros_r + 1'b1;
                left_nxt  = 6'd1;
                acc_nxt   = 32'h0;
              end
            end
            MODE_TAIL: res_value_nxt = ((32'd1 << zeros_r) - 32'd1) + acc_r;
            default: ;
          endcase
        end else if (read_short) begin
          res_status_nxt = STAT_EOD;
          res_value_nxt  = 32'h0;
        end else if (bib_r == 4'd0) begin
          ram_re     = 1'b1;
          fetch_nxt  = fetch_inc;
          mask_nxt   = fetch_inc < byte_total_r;
          second_nxt = 1'b0;
        end else begin
          acc_nxt  = bu_res.acc;
          left_nxt = bu_res.left;
          bib_nxt  = bu_res.bib;
          cur_nxt  = bu_res.cur;
          raw_nxt  = raw_r - RAW_W'(bu_res.take);
        end
      end
      ST_FETCH: begin
        if (second_r) begin
          // Byte after a dropped emulation byte, or byte 0 on rewind.
          cur_nxt  = fetch_byte;
          zrun_nxt = (fetch_byte == 8'h00) ? 2'd1 : 2'd0;
        end else begin
          bib_nxt = 4'(BYTE_BITS);
          if (skip_hit) begin
            // Drop the emulation byte; its bits still leave the budget.
            ram_re     = 1'b1;
            fetch_nxt  = fetch_inc;
            mask_nxt   = fetch_inc < byte_total_r;
            second_nxt = 1'b1;
            raw_nxt    = raw_less8;
          end else begin
            cur_nxt = fetch_byte;
            if (esc_en_r) begin
              if (fetch_byte == 8'h00) begin
                zrun_nxt = (zrun_r == 2'd2) ? 2'd2 : zrun_r + 1'b1;
              end else begin
                zrun_nxt = 2'd0;
              end
            end
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.value          = res_value_r;
          out_data_nxt.status         = res_status_r;
          out_data_nxt.remaining_bits = raw_sat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      byte_total_r <= '0;
      fetch_r      <= '0;
      cur_r        <= 8'h00;
      bib_r        <= 4'(BYTE_BITS);
      raw_r        <= '0;
      zrun_r       <= 2'd0;
      esc_en_r     <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      byte_total_r <= byte_total_nxt;
      fetch_r      <= fetch_nxt;
      cur_r        <= cur_nxt;
      bib_r        <= bib_nxt;
      raw_r        <= raw_nxt;
      zrun_r       <= zrun_nxt;
      if (cfg_valid && cfg_ready) begin
        esc_en_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    left_r       <= left_nxt;
    acc_r        <= acc_nxt;
    zeros_r      <= zeros_nxt;
    second_r     <= second_nxt;
    mask_r       <= mask_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

`default_nettype wire

### src/nbr_checker.sv
// Port-level checks of the NAL bit reader, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module nbr_checker
  import nbr_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire nbr_out_t out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Any error status carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_OK) |-> out_data.value == 32'h0)
    else $error("error result with nonzero value");

  // Reset empties the result register.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An accepted command leaves the block busy in the cycle after it.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted back to back");

endmodule

bind nal_bit_reader_exp_golomb_unit nbr_checker u_nbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
